[hdl/uct_pkg.sv]
// Shared constants, tag codes and character-class helpers for the URI component tagger.
package uct_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned TagW  = 3;
  localparam int unsigned ResW  = 2;
  localparam int unsigned PortW = 16;

  localparam logic [PortW-1:0] PortMax = 16'hFFFF;

  // Delimiter characters
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChAt    = 8'h40;
  localparam logic [CharW-1:0] ChQuery = 8'h3F;
  localparam logic [CharW-1:0] ChHash  = 8'h23;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Component tags
  localparam logic [TagW-1:0] TagNone     = 3'd0;
  localparam logic [TagW-1:0] TagScheme   = 3'd1;
  localparam logic [TagW-1:0] TagPending  = 3'd2;
  localparam logic [TagW-1:0] TagHost     = 3'd3;
  localparam logic [TagW-1:0] TagPath     = 3'd4;
  localparam logic [TagW-1:0] TagQuery    = 3'd5;
  localparam logic [TagW-1:0] TagFragment = 3'd6;

  // Pending-text resolution codes
  localparam logic [ResW-1:0] ResNone = 2'd0;
  localparam logic [ResW-1:0] ResUser = 2'd1;
  localparam logic [ResW-1:0] ResHost = 2'd2;

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_host_char(input logic [CharW-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChDot);
  endfunction

endpackage

[hdl/uri_component_tagger_core.sv]
// URI component tagger: per-character phase tracking, tagging and port accumulation.
// Each input transfer's result appears in the output register in the next cycle.
// Throughput: one character per cycle; input is stalled only while a held result is stalled.
// The phase register and the port accumulator set the per-character path.
// Reset (rst_ni low, asynchronous): scheme phase, port zero, no result held.
// After each final character the phase and port return to their reset values.
module uri_component_tagger_core
  import uct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_in_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] char_echo_o,
  output logic [TagW-1:0]  field_tag_o,
  output logic [ResW-1:0]  pending_resolve_o,
  output logic             uri_done_o,
  output logic             uri_valid_o,
  output logic [PortW-1:0] port_value_o
);

  typedef enum logic [3:0] {
    PhScheme    = 4'd0,
    PhColon     = 4'd1,
    PhSlash1    = 4'd2,
    PhPending   = 4'd3,
    PhAt        = 4'd4,
    PhHost      = 4'd5,
    PhPortStart = 4'd6,
    PhPort      = 4'd7,
    PhPath      = 4'd8,
    PhQuery     = 4'd9,
    PhFragment  = 4'd10,
    PhError     = 4'd11
  } phase_e;

  phase_e           phase_q, phase_d, next_ph;
  logic [PortW-1:0] port_q, port_d, port_new;
  logic             out_valid_q;
  logic [CharW-1:0] echo_q;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [ResW-1:0]  res_q, res_d;
  logic             done_q, valid_q;
  logic [PortW-1:0] portv_q;

  logic             in_xfer;
  logic [3:0]       digit;
  logic [PortW+3:0] mac;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign digit = 4'(char_in_i - ChZero);
  // acc * 10 + digit as shifts and adds
  assign mac   = ({port_q, 3'b000} + {3'b000, port_q, 1'b0}) + {16'd0, digit};

  always_comb begin
    tag_d    = TagNone;
    res_d    = ResNone;
    next_ph  = phase_q;
    port_new = port_q;
    unique case (phase_q)
      PhScheme: begin
        if (is_alpha(char_in_i)) tag_d = TagScheme;
        else if (char_in_i == ChColon) next_ph = PhColon;
        else next_ph = PhError;
      end
      PhColon:  next_ph = (char_in_i == ChSlash) ? PhSlash1 : PhError;
      PhSlash1: next_ph = (char_in_i == ChSlash) ? PhPending : PhError;
      PhPending: begin
        if (char_in_i == ChAt) begin
          res_d   = ResUser;
          next_ph = PhAt;
        end else if (char_in_i == ChColon) begin
          res_d   = ResHost;
          next_ph = PhPortStart;
        end else if (char_in_i == ChSlash) begin
          res_d   = ResHost;
          tag_d   = TagPath;
          next_ph = PhPath;
        end else if (last_char_i) begin
          res_d = ResHost;
          tag_d = TagHost;
        end else begin
          tag_d = TagPending;
        end
      end
      PhAt: begin
        if (is_host_char(char_in_i)) tag_d = TagHost;
        next_ph = PhHost;
      end
      PhHost: begin
        if (char_in_i == ChColon) next_ph = PhPortStart;
        else if (char_in_i == ChSlash) begin
          tag_d   = TagPath;
          next_ph = PhPath;
        end else if (is_host_char(char_in_i)) tag_d = TagHost;
        else next_ph = PhError;
      end
      PhPortStart: begin
        if (is_digit(char_in_i)) begin
          port_new = {12'd0, digit};
          next_ph  = PhPort;
        end else next_ph = PhError;
      end
      PhPort: begin
        if (is_digit(char_in_i)) begin
          // saturate once the value leaves 16 bits
          port_new = (mac[PortW+3:PortW] != 4'd0) ? PortMax : mac[PortW-1:0];
        end else if (char_in_i == ChSlash) begin
          tag_d   = TagPath;
          next_ph = PhPath;
        end else next_ph = PhError;
      end
      PhPath: begin
        if (char_in_i == ChQuery) next_ph = PhQuery;
        else if (char_in_i == ChHash) next_ph = PhFragment;
        else tag_d = TagPath;
      end
      PhQuery: begin
        if (char_in_i == ChHash) next_ph = PhFragment;
        else tag_d = TagQuery;
      end
      PhFragment: tag_d = TagFragment;
      default:    next_ph = PhError;
    endcase
    phase_d = last_char_i ? PhScheme : next_ph;
    port_d  = last_char_i ? '0 : port_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhScheme;
      port_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q <= phase_d;
        port_q  <= port_d;
      end
      // hold while the result is stalled, else load or drain
      if (!in_stall_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      echo_q  <= char_in_i;
      tag_q   <= tag_d;
      res_q   <= res_d;
      done_q  <= last_char_i;
      valid_q <= (next_ph != PhError);
      portv_q <= port_new;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign char_echo_o       = echo_q;
  assign field_tag_o       = tag_q;
  assign pending_resolve_o = res_q;
  assign uri_done_o        = done_q;
  assign uri_valid_o       = valid_q;
  assign port_value_o      = portv_q;

`ifndef NO_ASSERTIONS
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_char_i |=> (phase_q == PhScheme) && (port_q == '0))
    else $error("phase or port not cleared after final character");

  a_error_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !uri_valid_o |-> (field_tag_o == TagNone))
    else $error("tagged character reported with a syntax error");

  a_pending_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_tag_o == TagPending) |-> !uri_done_o)
    else $error("final character left pending");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");
`endif

endmodule

[bench/uri_component_tagger_core_tb.sv]
// Self-checking testbench for the URI component tagger core: directed table, then random URIs.
module uri_component_tagger_core_tb;
  import uct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PhScheme, PhColon, PhSlash1, PhPending, PhAt, PhHost,
    PhPortStart, PhPort, PhPath, PhQuery, PhFragment, PhError
  } parse_phase_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [TagW-1:0]  tag;
    logic [ResW-1:0]  res;
    logic             done;
    logic             valid;
    logic [PortW-1:0] port;
  } tag_result_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    bit               chk;
    logic [TagW-1:0]  tag;
    logic [ResW-1:0]  res;
    logic             valid;
    logic [PortW-1:0] port;
  } char_row_t;

  typedef logic [CharW-1:0] text_q_t[$];

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CharW-1:0] char_in_i;
  logic             last_char_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [CharW-1:0] char_echo_o;
  logic [TagW-1:0]  field_tag_o;
  logic [ResW-1:0]  pending_resolve_o;
  logic             uri_done_o;
  logic             uri_valid_o;
  logic [PortW-1:0] port_value_o;

  // typed-in expectation travelling with the current transfer
  bit               row_chk;
  tag_result_t      row_exp;

  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  bit               long_hold_req;
  int unsigned      mismatch_count;
  tag_result_t      tag_results_due[$];

  parse_phase_e     cur_phase = PhScheme;
  logic [PortW-1:0] port_acc  = '0;

  // character, last, typed?, tag, resolve, valid, port
  char_row_t char_rows [25] = '{
    '{8'h41, 1'b0, 1'b1, TagScheme,   ResNone, 1'b1, 16'd0},     // 'A'
    '{ChColon, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChSlash, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChSlash, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{8'h75, 1'b0, 1'b1, TagPending,  ResNone, 1'b1, 16'd0},     // 'u'
    '{ChAt,  1'b0, 1'b1, TagNone,     ResUser, 1'b1, 16'd0},
    '{8'h2D, 1'b0, 1'b1, TagNone,     ResNone, 1'b1, 16'd0},     // '-' dropped after '@'
    '{8'h39, 1'b0, 1'b0, TagNone,     ResNone, 1'b1, 16'd0},
    '{ChColon, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{8'h37, 1'b0, 1'b0, TagNone,     ResNone, 1'b1, 16'd0},
    '{ChZero, 1'b0, 1'b0, TagNone,    ResNone, 1'b1, 16'd0},
    '{ChZero, 1'b0, 1'b0, TagNone,    ResNone, 1'b1, 16'd0},
    '{ChZero, 1'b0, 1'b0, TagNone,    ResNone, 1'b1, 16'd0},
    '{ChZero, 1'b0, 1'b1, TagNone,    ResNone, 1'b1, PortMax},   // 70000 saturates
    '{ChSlash, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChQuery, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChHash, 1'b0, 1'b0, TagNone,    ResNone, 1'b1, 16'd0},
    '{ChHash, 1'b1, 1'b1, TagFragment, ResNone, 1'b1, PortMax},
    '{8'hFF, 1'b0, 1'b1, TagNone,     ResNone, 1'b0, 16'd0},
    '{8'h00, 1'b1, 1'b1, TagNone,     ResNone, 1'b0, 16'd0},
    '{8'h7A, 1'b0, 1'b0, TagNone,     ResNone, 1'b1, 16'd0},     // 'z'
    '{ChColon, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChSlash, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{ChSlash, 1'b0, 1'b0, TagNone,   ResNone, 1'b1, 16'd0},
    '{8'h68, 1'b1, 1'b1, TagHost,     ResHost, 1'b1, 16'd0}      // pending text ends as host
  };

  uri_component_tagger_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .char_in_i         (char_in_i),
    .last_char_i       (last_char_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .char_echo_o       (char_echo_o),
    .field_tag_o       (field_tag_o),
    .pending_resolve_o (pending_resolve_o),
    .uri_done_o        (uri_done_o),
    .uri_valid_o       (uri_valid_o),
    .port_value_o      (port_value_o)
  );

  function automatic bit letter_ch(input logic [CharW-1:0] c);
    logic [CharW-1:0] up;
    up = c & 8'hDF;
    return (up >= 8'h41) && (up <= 8'h5A);
  endfunction

  function automatic bit digit_ch(input logic [CharW-1:0] c);
    return (c[7:4] == 4'h3) && (c[3:0] <= 4'd9);
  endfunction

  function automatic bit hostname_ch(input logic [CharW-1:0] c);
    return letter_ch(c) || digit_ch(c) || (c == ChDot);
  endfunction

  // Tag one character and advance the parse phase and port accumulator.
  function automatic tag_result_t tag_char(input logic [CharW-1:0] c, input logic last);
    tag_result_t  r;
    parse_phase_e nxt;
    int unsigned  acc;
    r.ch   = c;
    r.tag  = TagNone;
    r.res  = ResNone;
    r.done = last;
    nxt    = cur_phase;
    case (cur_phase)
      PhScheme: begin
        if (letter_ch(c)) r.tag = TagScheme;
        else if (c == ChColon) nxt = PhColon;
        else nxt = PhError;
      end
      PhColon:  nxt = (c == ChSlash) ? PhSlash1 : PhError;
      PhSlash1: nxt = (c == ChSlash) ? PhPending : PhError;
      PhPending: begin
        if (c == ChAt) begin
          r.res = ResUser;
          nxt   = PhAt;
        end else if (c == ChColon) begin
          r.res = ResHost;
          nxt   = PhPortStart;
        end else if (c == ChSlash) begin
          r.res = ResHost;
          r.tag = TagPath;
          nxt   = PhPath;
        end else if (last) begin
          r.res = ResHost;
          r.tag = TagHost;
        end else begin
          r.tag = TagPending;
        end
      end
      PhAt: begin
        if (hostname_ch(c)) r.tag = TagHost;
        nxt = PhHost;
      end
      PhHost: begin
        if (c == ChColon) nxt = PhPortStart;
        else if (c == ChSlash) begin
          r.tag = TagPath;
          nxt   = PhPath;
        end else if (hostname_ch(c)) r.tag = TagHost;
        else nxt = PhError;
      end
      PhPortStart: begin
        if (digit_ch(c)) begin
          port_acc = PortW'(c - ChZero);
          nxt      = PhPort;
        end else nxt = PhError;
      end
      PhPort: begin
        if (digit_ch(c)) begin
          acc      = port_acc * 10 + (c - ChZero);
          port_acc = (acc > PortMax) ? PortMax : acc[PortW-1:0];
        end else if (c == ChSlash) begin
          r.tag = TagPath;
          nxt   = PhPath;
        end else nxt = PhError;
      end
      PhPath: begin
        if (c == ChQuery) nxt = PhQuery;
        else if (c == ChHash) nxt = PhFragment;
        else r.tag = TagPath;
      end
      PhQuery: begin
        if (c == ChHash) nxt = PhFragment;
        else r.tag = TagQuery;
      end
      PhFragment: r.tag = TagFragment;
      default:    nxt = PhError;
    endcase
    r.valid = (nxt != PhError);
    r.port  = port_acc;
    if (last) begin
      cur_phase = PhScheme;
      port_acc  = '0;
    end else begin
      cur_phase = nxt;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic compare_result(input tag_result_t got, input tag_result_t want);
    if (got.ch !== want.ch)
      report_mismatch("char_echo", 32'(got.ch), 32'(want.ch));
    if (got.tag !== want.tag)
      report_mismatch("field_tag", 32'(got.tag), 32'(want.tag));
    if (got.res !== want.res)
      report_mismatch("pending_resolve", 32'(got.res), 32'(want.res));
    if (got.done !== want.done)
      report_mismatch("uri_done", 32'(got.done), 32'(want.done));
    if (got.valid !== want.valid)
      report_mismatch("uri_valid", 32'(got.valid), 32'(want.valid));
    if (got.port !== want.port)
      report_mismatch("port_value", 32'(got.port), 32'(want.port));
  endtask

  function automatic logic [CharW-1:0] pick_host_ch();
    case ($urandom_range(3))
      0:       return CharW'(8'h41 + $urandom_range(25));
      1:       return CharW'(8'h61 + $urandom_range(25));
      2:       return CharW'(ChZero + $urandom_range(9));
      default: return ChDot;
    endcase
  endfunction

  // Mostly well-formed URIs with random content; the rest noise, corrupted or truncated.
  task automatic compose_uri(ref text_q_t s);
    s = {};
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) s.push_back(CharW'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 6))
      s.push_back(CharW'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25)));
    s.push_back(ChColon);
    s.push_back(ChSlash);
    s.push_back(ChSlash);
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(0, 4)) s.push_back(pick_host_ch());
      s.push_back(ChAt);
      s.push_back($urandom_range(1) ? pick_host_ch() : CharW'($urandom_range(255)));
    end
    repeat ($urandom_range(1, 6)) s.push_back(pick_host_ch());
    if ($urandom_range(1)) begin
      s.push_back(ChColon);
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 8 : 4))
        s.push_back(CharW'(ChZero + $urandom_range(9)));
    end
    if ($urandom_range(1)) begin
      s.push_back(ChSlash);
      repeat ($urandom_range(0, 5)) s.push_back(CharW'($urandom_range(255)));
      if ($urandom_range(1)) begin
        s.push_back(ChQuery);
        repeat ($urandom_range(0, 4)) s.push_back(CharW'($urandom_range(255)));
      end
      if ($urandom_range(1)) begin
        s.push_back(ChHash);
        repeat ($urandom_range(0, 4))
          s.push_back(($urandom_range(3) == 0) ? ChHash : CharW'($urandom_range(255)));
      end
    end
    case ($urandom_range(9))
      0:       s[$urandom_range(s.size() - 1)] = CharW'($urandom_range(255));
      1:       s = s[0:$urandom_range(s.size() - 1)];
      default: ;
    endcase
  endtask

  // Offer one character and hold it until the transfer.
  task automatic send_char(input logic [CharW-1:0] c, input logic last, input bit chk,
                           input tag_result_t exp_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_in_i   <= c;
    last_char_i <= last;
    row_chk     <= chk;
    row_exp     <= exp_res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stall, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 60;
        out_stall_i   <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    tag_result_t got;
    tag_result_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {char_echo_o, field_tag_o, pending_resolve_o, uri_done_o, uri_valid_o,
               port_value_o};
        if (tag_results_due.size() == 0)
          report_mismatch("unexpected result", 32'(got.ch), 0);
        else compare_result(got, tag_results_due.pop_front());
      end
      if (in_valid_i && !in_stall_o) begin
        pred = tag_char(char_in_i, last_char_i);
        tag_results_due.push_back(row_chk ? row_exp : pred);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("uri_component_tagger_core_tb NOT OK");
    $finish;
  end

  initial begin
    text_q_t     uri;
    int unsigned sent;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_in_i      = '0;
    last_char_i    = 1'b0;
    row_chk        = 1'b0;
    row_exp        = '0;
    long_hold_req  = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 11;
    recv_idle_pct  = 86;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (char_rows[i])
      send_char(char_rows[i].ch, char_rows[i].last, char_rows[i].chk,
                tag_result_t'{char_rows[i].ch, char_rows[i].tag, char_rows[i].res,
                              char_rows[i].last, char_rows[i].valid, char_rows[i].port});

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 11 : (stage == 1) ? 86 : 0;
      recv_idle_pct = (stage == 0) ? 86 : (stage == 1) ? 11 : 0;
      // keep offering while the receiver holds off, so the block backs up
      if (stage == 2) long_hold_req = 1'b1;
      sent = 0;
      while (sent < 260) begin
        compose_uri(uri);
        foreach (uri[k]) send_char(uri[k], k == uri.size() - 1, 1'b0, '0);
        sent += uri.size();
      end
    end
    in_valid_i <= 1'b0;

    while (tag_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tag_results_due.size() != 0)
      report_mismatch("missing results", unsigned'(tag_results_due.size()), 0);

    if (mismatch_count == 0) begin
      $display("uri_component_tagger_core_tb OK");
    end else begin
      $display("uri_component_tagger_core_tb NOT OK");
    end
    $finish;
  end

endmodule
